@@ design/bols_pkg.sv @@
// ----------------------------------------------------------------------------
// bols_pkg
// Shared types and codes for the bounded ordered list store.
// ----------------------------------------------------------------------------
package bols_pkg;

  localparam int DEPTH_DEFAULT = 32;
  localparam int VALUE_W       = 32;
  localparam int POS_W         = 7;
  localparam int REQ_W         = 3;
  localparam int STATUS_W      = 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_INS_HEAD = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INS_TAIL = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DEL_HEAD = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DEL_TAIL = 3'd3;
  localparam logic [REQ_W-1:0] REQ_INS_POS  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_READ_ALL = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]          req_type;
    logic signed [VALUE_W-1:0] item_value;
    logic [POS_W-1:0]          insert_position;
  } req_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] result_value;
    logic [STATUS_W-1:0]       status;
    logic                      last_of_run;
  } rsp_item_t;

endpackage

@@ design/bols_ram.sv @@
// ----------------------------------------------------------------------------
// bols_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bols_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/bols_out.sv @@
// ----------------------------------------------------------------------------
// bols_out
// Output register stage between the sequencer and the response channel.
// ----------------------------------------------------------------------------
module bols_out
  import bols_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_ready,
  input  rsp_item_t push,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_item_t rsp
);

  assign push_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (push_ready) begin
      rsp_valid <= push_valid;
    end
    if (push_valid && push_ready) begin
      rsp <= push;
    end
  end

endmodule

@@ design/bols_seq.sv @@
// ----------------------------------------------------------------------------
// bols_seq
// Request sequencer: walks the element RAM entry by entry to shift,
// fetch and list elements, and hands results to the output stage.
// ----------------------------------------------------------------------------
module bols_seq
  import bols_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_item_t req,
  output logic      push_valid,
  input  logic      push_ready,
  output rsp_item_t push
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SH_RD,
    S_SH_WR,
    S_PLACE,
    S_DH_CAP,
    S_SD_WR,
    S_DT_CAP,
    S_RO_RD,
    S_RO_DATA,
    S_DONE
  } state_t;

  state_t    state;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] slot;
  req_item_t cur;
  rsp_item_t res;

  logic [CW-1:0] idx_m1;
  logic [CW-1:0] idx_m2;
  logic [CW-1:0] idx_p1;
  logic [CW-1:0] count_m1;
  logic [CW-1:0] ins_slot;
  logic [POS_W:0] count_p1_ext;
  logic          is_full;
  logic          is_empty;
  logic          pos_bad;
  logic          ro_last;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  assign idx_m1       = idx - CW'(1);
  assign idx_m2       = idx - CW'(2);
  assign idx_p1       = idx + CW'(1);
  assign count_m1     = count - CW'(1);
  assign count_p1_ext = (POS_W + 1)'(count) + (POS_W + 1)'(1);
  assign is_full      = (count == CW'(DEPTH));
  assign is_empty     = (count == '0);
  assign pos_bad      = (cur.insert_position == '0) ||
                        ((POS_W + 1)'(cur.insert_position) > count_p1_ext);
  assign ro_last      = (idx_p1 == count);

  always_comb begin
    case (cur.req_type)
      REQ_INS_HEAD: ins_slot = '0;
      REQ_INS_TAIL: ins_slot = count;
      default:      ins_slot = CW'(cur.insert_position - POS_W'(1));
    endcase
  end

  assign req_ready = (state == S_IDLE) && !rst;

  assign push_valid = (state == S_RO_DATA) || (state == S_DONE);
  always_comb begin
    if (state == S_RO_DATA) begin
      push.result_value = ram_rdata;
      push.status       = ST_OK;
      push.last_of_run  = ro_last;
    end else begin
      push = res;
    end
  end

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx[AW-1:0];
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = idx[AW-1:0];
    case (state)
      S_DISPATCH: begin
        if (!is_empty) begin
          if (cur.req_type == REQ_DEL_HEAD || cur.req_type == REQ_READ_ALL) begin
            ram_re    = 1'b1;
            ram_raddr = '0;
          end else if (cur.req_type == REQ_DEL_TAIL) begin
            ram_re    = 1'b1;
            ram_raddr = count_m1[AW-1:0];
          end
        end
      end
      S_SH_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_m1[AW-1:0];
      end
      S_SH_WR: begin
        ram_we = 1'b1;
        if (idx_m1 != slot) begin
          ram_re    = 1'b1;
          ram_raddr = idx_m2[AW-1:0];
        end
      end
      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = slot[AW-1:0];
        ram_wdata = cur.item_value;
      end
      S_DH_CAP: begin
        ram_re = (idx != count);
      end
      S_SD_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_m1[AW-1:0];
        if (idx_p1 != count) begin
          ram_re    = 1'b1;
          ram_raddr = idx_p1[AW-1:0];
        end
      end
      S_RO_RD: begin
        ram_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur   <= req;
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          case (cur.req_type)
            REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_POS: begin
              if (is_full) begin
                res   <= '{result_value: '0, status: ST_FULL, last_of_run: 1'b1};
                state <= S_DONE;
              end else if (cur.req_type == REQ_INS_POS && pos_bad) begin
                res   <= '{result_value: '0, status: ST_RANGE, last_of_run: 1'b1};
                state <= S_DONE;
              end else begin
                slot  <= ins_slot;
                idx   <= count;
                state <= (ins_slot == count) ? S_PLACE : S_SH_RD;
              end
            end
            REQ_DEL_HEAD, REQ_DEL_TAIL, REQ_READ_ALL: begin
              if (is_empty) begin
                res   <= '{result_value: '0, status: ST_EMPTY, last_of_run: 1'b1};
                state <= S_DONE;
              end else if (cur.req_type == REQ_DEL_HEAD) begin
                idx   <= CW'(1);
                state <= S_DH_CAP;
              end else if (cur.req_type == REQ_DEL_TAIL) begin
                state <= S_DT_CAP;
              end else begin
                idx   <= '0;
                state <= S_RO_DATA;
              end
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end
        S_SH_RD: begin
          state <= S_SH_WR;
        end
        S_SH_WR: begin
          idx <= idx_m1;
          if (idx_m1 == slot) begin
            state <= S_PLACE;
          end
        end
        S_PLACE: begin
          count <= count + CW'(1);
          res   <= '{result_value: '0, status: ST_OK, last_of_run: 1'b1};
          state <= S_DONE;
        end
        S_DH_CAP: begin
          res <= '{result_value: ram_rdata, status: ST_OK, last_of_run: 1'b1};
          if (idx == count) begin
            count <= count_m1;
            state <= S_DONE;
          end else begin
            state <= S_SD_WR;
          end
        end
        S_SD_WR: begin
          idx <= idx_p1;
          if (idx_p1 == count) begin
            count <= count_m1;
            state <= S_DONE;
          end
        end
        S_DT_CAP: begin
          res   <= '{result_value: ram_rdata, status: ST_OK, last_of_run: 1'b1};
          count <= count_m1;
          state <= S_DONE;
        end
        S_RO_RD: begin
          state <= S_RO_DATA;
        end
        S_RO_DATA: begin
          if (push_ready) begin
            if (ro_last) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx_p1;
              state <= S_RO_RD;
            end
          end
        end
        S_DONE: begin
          if (push_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  bols_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("element count above depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && count != $past(count)) |->
      (count == $past(count) + CW'(1) || count + CW'(1) == $past(count)))
    else $error("element count moved by more than one");

  a_write_in_list: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (CW'(ram_waddr) <= count))
    else $error("write beyond end of list");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (push_valid && push_ready && push.last_of_run) |=> (state == S_IDLE))
    else $error("sequencer busy after final result");

endmodule

@@ design/bounded_ordered_list_store.sv @@
// ----------------------------------------------------------------------------
// bounded_ordered_list_store
// Ordered list of up to DEPTH signed 32-bit values held in one RAM.
// ----------------------------------------------------------------------------
// Requests enter on req_valid/req_ready with a req_item_t payload; results
// leave on rsp_valid/rsp_ready as rsp_item_t. One request is in work at a
// time; req_ready is high only while the sequencer is idle.
// Inserts and deletes give one result, a read-all gives one result per
// element with last_of_run on the final one (one result, status empty, if
// the list is empty). Request codes 6 and 7 give nothing.
// An insert shifts the elements from the tail down to its slot one place
// back, then writes the value; an append writes at once. A delete head
// moves every later element one place forward. Each request walks the
// single RAM port pair entry by entry.
// A result waits in the output register while the next request is taken.
// If rsp_ready stays low the sequencer holds its next result and stops.
// Reset empties the list at once; stored words are not cleared.
// ----------------------------------------------------------------------------
module bounded_ordered_list_store
  import bols_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_item_t rsp
);

  logic      push_valid;
  logic      push_ready;
  rsp_item_t push;

  bols_seq #(
    .DEPTH(DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push      (push)
  );

  bols_out u_out (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push      (push),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

@@ sim/bounded_ordered_list_store_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_ordered_list_store_test
// Self-checking bench for the bounded ordered list store.
// ----------------------------------------------------------------------------
// A directed table covers the corner cases: an empty list, a full list, bad
// positions, appends at count+1 and undefined requests. After that, random
// request streams swing between filling and draining the list under four
// idling mixes, with one long receiver hold-off. Each accepted transaction
// updates a local copy of the list. Results are checked in order against the
// queued expectations.
// ----------------------------------------------------------------------------
module bounded_ordered_list_store_test;
  import bols_pkg::*;

  localparam int LIST_DEPTH      = DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS    = 80;
  localparam int PRESSURE_ITEMS  = 20;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_LIMIT     = 20000;

  localparam logic [REQ_W-1:0] REQ_RSVD_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_RSVD_7 = 3'd7;

  localparam rsp_item_t R_OK     = '{32'sd0, ST_OK, 1'b1};
  localparam rsp_item_t R_EMPTY  = '{32'sd0, ST_EMPTY, 1'b1};
  localparam rsp_item_t R_FULL   = '{32'sd0, ST_FULL, 1'b1};
  localparam rsp_item_t R_RANGE  = '{32'sd0, ST_RANGE, 1'b1};
  localparam rsp_item_t NO_CHECK = '0;

  typedef struct {
    req_item_t item;
    int        reps;
    bit        typed;
    rsp_item_t want;
  } dir_row_t;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  req_item_t req       = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rsp_item_t rsp;

  logic signed [VALUE_W-1:0] list_mem [LIST_DEPTH];
  int        list_len      = 0;
  rsp_item_t want_q[$];
  int        err_count     = 0;
  int        send_idle_pct = 0;
  int        rsp_stall_pct = 0;
  int        hold_left     = 0;
  bit        filling       = 1'b1;

  // reps > 1 rows take random values
  dir_row_t dir_tab [25] = '{
    '{'{REQ_DEL_HEAD, 32'sd0, 7'd0}, 1, 1'b1, R_EMPTY},
    '{'{REQ_DEL_TAIL, 32'sd0, 7'd0}, 1, 1'b1, R_EMPTY},
    '{'{REQ_READ_ALL, 32'sd0, 7'd0}, 1, 1'b1, R_EMPTY},
    '{'{REQ_INS_POS, 32'sd123, 7'd0}, 1, 1'b1, R_RANGE},
    '{'{REQ_INS_POS, 32'sd123, 7'd2}, 1, 1'b1, R_RANGE},
    '{'{REQ_INS_POS, 32'sh7FFF_FFFF, 7'd1}, 1, 1'b1, R_OK},
    '{'{REQ_INS_HEAD, 32'sh8000_0000, 7'd0}, 1, 1'b1, R_OK},
    '{'{REQ_INS_TAIL, -32'sd1, 7'd127}, 1, 1'b1, R_OK},
    '{'{REQ_INS_POS, 32'sd0, 7'd4}, 1, 1'b1, R_OK},
    '{'{REQ_INS_POS, 32'sd5, 7'd2}, 1, 1'b1, R_OK},
    '{'{REQ_INS_POS, 32'sd9, 7'd7}, 1, 1'b1, R_RANGE},
    '{'{REQ_READ_ALL, -32'sd1, 7'd127}, 1, 1'b0, NO_CHECK},
    '{'{REQ_INS_POS, 32'sd9, 7'd127}, 1, 1'b1, R_RANGE},
    '{'{REQ_DEL_HEAD, 32'sd0, 7'd0}, 1, 1'b0, NO_CHECK},
    '{'{REQ_DEL_TAIL, 32'sd0, 7'd0}, 1, 1'b0, NO_CHECK},
    '{'{REQ_RSVD_6, 32'sd77, 7'd1}, 1, 1'b0, NO_CHECK},
    '{'{REQ_RSVD_7, -32'sd1, 7'd127}, 1, 1'b0, NO_CHECK},
    '{'{REQ_INS_TAIL, 32'sd0, 7'd0}, LIST_DEPTH - 3, 1'b1, R_OK},
    '{'{REQ_INS_HEAD, 32'sd1, 7'd0}, 1, 1'b1, R_FULL},
    '{'{REQ_INS_TAIL, 32'sd1, 7'd0}, 1, 1'b1, R_FULL},
    '{'{REQ_INS_POS, 32'sd1, 7'd0}, 1, 1'b1, R_FULL},
    '{'{REQ_INS_POS, 32'sd1, 7'd33}, 1, 1'b1, R_FULL},
    '{'{REQ_READ_ALL, 32'sd0, 7'd0}, 1, 1'b0, NO_CHECK},
    '{'{REQ_DEL_TAIL, 32'sd0, 7'd0}, LIST_DEPTH, 1'b0, NO_CHECK},
    '{'{REQ_DEL_TAIL, 32'sd0, 7'd0}, 1, 1'b1, R_EMPTY}
  };

  bounded_ordered_list_store #(
    .DEPTH(LIST_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void predict_list(input req_item_t it, output rsp_item_t res[$]);
    rsp_item_t r;
    int        slot;
    res = {};
    r = '0;
    r.last_of_run = 1'b1;
    case (it.req_type)
      REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_POS: begin
        if (list_len >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else if (it.req_type == REQ_INS_POS && (it.insert_position == 0 ||
                     int'(it.insert_position) > list_len + 1)) begin
          r.status = ST_RANGE;
        end else begin
          if (it.req_type == REQ_INS_HEAD) slot = 0;
          else if (it.req_type == REQ_INS_TAIL) slot = list_len;
          else slot = int'(it.insert_position) - 1;
          for (int i = list_len; i > slot; i--) list_mem[i] = list_mem[i-1];
          list_mem[slot] = it.item_value;
          list_len++;
          r.status = ST_OK;
        end
        res.push_back(r);
      end
      REQ_DEL_HEAD, REQ_DEL_TAIL: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else if (it.req_type == REQ_DEL_HEAD) begin
          r.result_value = list_mem[0];
          for (int i = 1; i < list_len; i++) list_mem[i-1] = list_mem[i];
          list_len--;
          r.status = ST_OK;
        end else begin
          list_len--;
          r.result_value = list_mem[list_len];
          r.status = ST_OK;
        end
        res.push_back(r);
      end
      REQ_READ_ALL: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
          res.push_back(r);
        end
        for (int i = 0; i < list_len; i++) begin
          r.result_value = list_mem[i];
          r.status = ST_OK;
          r.last_of_run = (i == list_len - 1);
          res.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(19))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic req_item_t pick_req();
    req_item_t it;
    int        roll;
    it.item_value = pick_value();
    it.insert_position = POS_W'($urandom);
    roll = $urandom_range(99);
    if (filling) begin
      if (roll < 20) it.req_type = REQ_INS_HEAD;
      else if (roll < 40) it.req_type = REQ_INS_TAIL;
      else if (roll < 62) it.req_type = REQ_INS_POS;
      else if (roll < 74) it.req_type = REQ_DEL_HEAD;
      else if (roll < 84) it.req_type = REQ_DEL_TAIL;
      else if (roll < 96) it.req_type = REQ_READ_ALL;
      else it.req_type = ($urandom_range(1) == 0) ? REQ_RSVD_6 : REQ_RSVD_7;
    end else begin
      if (roll < 9) it.req_type = REQ_INS_HEAD;
      else if (roll < 18) it.req_type = REQ_INS_TAIL;
      else if (roll < 28) it.req_type = REQ_INS_POS;
      else if (roll < 58) it.req_type = REQ_DEL_HEAD;
      else if (roll < 86) it.req_type = REQ_DEL_TAIL;
      else if (roll < 96) it.req_type = REQ_READ_ALL;
      else it.req_type = ($urandom_range(1) == 0) ? REQ_RSVD_6 : REQ_RSVD_7;
    end
    if (it.req_type == REQ_INS_POS && $urandom_range(9) != 0)
      it.insert_position = POS_W'($urandom_range(list_len + 1, 1));
    else if (it.req_type == REQ_INS_POS && $urandom_range(3) == 0)
      it.insert_position = '0;
    return it;
  endfunction

  // entered and left at a falling edge
  task automatic send_req(input req_item_t it, input bit typed, input rsp_item_t want);
    rsp_item_t res[$];
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_valid = 1'b1;
    req = it;
    do @(posedge clk); while (!req_ready);
    predict_list(it, res);
    if (typed) want_q.push_back(want);
    else foreach (res[i]) want_q.push_back(res[i]);
    @(negedge clk);
  endtask

  task automatic run_random(input int n);
    for (int k = 0; k < n; k++) begin
      send_req(pick_req(), 1'b0, NO_CHECK);
      if (list_len == LIST_DEPTH && $urandom_range(3) == 0) filling = 1'b0;
      else if (list_len == 0 && $urandom_range(3) == 0) filling = 1'b1;
      else if ($urandom_range(49) == 0) filling = !filling;
    end
  endtask

  task automatic set_phase(input int s_pct, input int r_pct, input int hold);
    req_valid = 1'b0;
    @(posedge clk);
    send_idle_pct = s_pct;
    rsp_stall_pct = r_pct;
    hold_left = hold;
    @(negedge clk);
  endtask

  task automatic drain_results();
    req_valid = 1'b0;
    for (int g = 0; want_q.size() != 0 && g < DRAIN_LIMIT; g++) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      rsp_ready = 1'b0;
      hold_left--;
    end else begin
      rsp_ready = ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  always @(posedge clk) begin : rsp_check
    rsp_item_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (want_q.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result: value %0d status %0d last %0b",
                 $time, rsp.result_value, rsp.status, rsp.last_of_run);
      end else begin
        want = want_q.pop_front();
        if (rsp.result_value !== want.result_value || rsp.status !== want.status ||
            rsp.last_of_run !== want.last_of_run) begin
          err_count++;
          $display("%0t: result mismatch: expected value %0d status %0d last %0b, %s",
                   $time, want.result_value, want.status, want.last_of_run,
                   $sformatf("got value %0d status %0d last %0b",
                             rsp.result_value, rsp.status, rsp.last_of_run));
        end
      end
    end
  end

  initial begin : stimulus
    dir_row_t  row;
    req_item_t it;
    int        s_mix [4];
    int        r_mix [4];
    s_mix = '{0, 72, 0, 7};
    r_mix = '{0, 0, 72, 7};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_tab[n]) begin
      row = dir_tab[n];
      for (int k = 0; k < row.reps; k++) begin
        it = row.item;
        if (row.reps > 1) it.item_value = $urandom;
        send_req(it, row.typed, row.want);
      end
    end
    drain_results();

    // receiver blocked while requests keep coming, so the input backs up
    filling = 1'b1;
    set_phase(0, 0, HOLD_OFF_CYCLES);
    run_random(PRESSURE_ITEMS);
    drain_results();

    for (int p = 0; p < 4; p++) begin
      set_phase(s_mix[p], r_mix[p], 0);
      run_random(RANDOM_ITEMS);
      drain_results();
    end

    set_phase(0, 0, 0);
    drain_results();
    repeat (100) @(negedge clk);
    if (want_q.size() != 0) begin
      err_count++;
      $display("%0t: %0d expected results never arrived", $time, want_q.size());
    end
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/bols_pkg.sv
design/bols_ram.sv
design/bols_out.sv
design/bols_seq.sv
design/bounded_ordered_list_store.sv
sim/bounded_ordered_list_store_test.sv
